// ===== rtl/omru_pkg.sv =====
package omru_pkg;

	localparam int MASK_REGS = 8;
	localparam int MASK_W    = 16;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 8;
	localparam int ACT_W     = 4;
	localparam int RAM_AW    = (MASK_REGS > 1) ? $clog2(MASK_REGS) : 1;

	localparam int IN_W  = 40;
	localparam int OUT_W = 24;

	localparam logic [MASK_W-1:0] MASK_ALL  = 16'hffff;
	localparam logic [CNT_W-1:0]  MAX_SHIFT = 8'd15;
	localparam int                BYTE_BITS = 8;

	typedef enum logic [ACT_W-1:0] {
		ACT_AND    = 4'd0,
		ACT_ANDN   = 4'd1,
		ACT_OR     = 4'd2,
		ACT_XOR    = 4'd3,
		ACT_XNOR   = 4'd4,
		ACT_NOT    = 4'd5,
		ACT_MOVE   = 4'd6,
		ACT_LOAD   = 4'd7,
		ACT_STORE  = 4'd8,
		ACT_UNPACK = 4'd9,
		ACT_ORTEST = 4'd10,
		ACT_SHL    = 4'd11,
		ACT_SHR    = 4'd12
	} act_t;

	typedef struct packed {
		logic [MASK_W-1:0] load_word;
		logic [CNT_W-1:0]  shift_count;
		logic [IDX_W-1:0]  second_source;
		logic [IDX_W-1:0]  first_source;
		logic [IDX_W-1:0]  dest_index;
		logic [ACT_W-1:0]  action;
	} in_item_t;

	typedef struct packed {
		logic              carry_flag;
		logic              zero_flag;
		logic              flags_valid;
		logic [MASK_W-1:0] store_word;
		logic              store_valid;
		logic              ud_fault;
	} out_item_t;

	function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
		return {1'b0, idx} < (IDX_W + 1)'(MASK_REGS);
	endfunction

endpackage

// ===== rtl/omru_ram.sv =====
module omru_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/opmask_register_unit.sv =====
// opmask_register_unit: eight 16-bit mask registers with the word-size mask
// instructions (and, andn, or, xor, xnor, not, move, load, store, unpack,
// ortest, shift left, shift right).
// input channel s_*: one instruction item per handshake; tdata carries
// action, dest_index, first_source, second_source, shift_count, load_word.
// output channel m_*: exactly one result item per instruction, in order.
// config channel cfg_*: one-bit opmask enable, always ready; write it only
// while no instruction is in flight.
// path: execute register, then output register. throughput: one instruction
// per cycle while results are taken; a mask written by one instruction is
// forwarded to the next one with no bubble.
// the register file is a ram read at accept time with per-entry valid bits;
// a register never written since reset reads as zero.
// reset: all masks read as zero, opmask disabled (every item faults).
// stall: when m_tready is low the result holds; one more instruction is
// taken into the execute register, then s_tready drops until the result
// is taken.
module opmask_register_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// action[3:0] dest_index[6:4] first_source[9:7] second_source[12:10]
	// shift_count[20:13] load_word[36:21] zero[39:37]
	input  logic [omru_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// ud_fault[0] store_valid[1] store_word[17:2] flags_valid[18]
	// zero_flag[19] carry_flag[20] zero[23:21]
	output logic [omru_pkg::OUT_W-1:0] m_tdata
);
	import omru_pkg::*;

	localparam int ITEM_IN_W  = $bits(in_item_t);
	localparam int ITEM_OUT_W = $bits(out_item_t);

	logic              enabled_q;
	logic              valid_s1;
	in_item_t          item_s1;
	logic              a_ok_s1, b_ok_s1, a_byp_s1, b_byp_s1;
	logic [MASK_W-1:0] byp_data_s1;
	logic [MASK_REGS-1:0] vld_q;
	out_item_t         out_q;

	in_item_t          in_item;
	logic              s_accept, advance;
	logic              wr_en;
	logic [MASK_W-1:0] wr_data;
	logic [MASK_W-1:0] ram_a, ram_b, a_val, b_val, or_val;
	logic              writes;
	out_item_t         res;
	act_t              act;

	assign cfg_ready = 1'b1;
	assign in_item   = in_item_t'(s_tdata[ITEM_IN_W-1:0]);
	assign advance   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_accept  = s_tvalid && s_tready;
	assign act       = act_t'(item_s1.action);

	omru_ram #(.WIDTH(MASK_W), .DEPTH(MASK_REGS), .AW(RAM_AW)) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (item_s1.dest_index[RAM_AW-1:0]),
		.wdata   (wr_data),
		.re      (s_accept),
		.raddr_a (in_item.first_source[RAM_AW-1:0]),
		.raddr_b (in_item.second_source[RAM_AW-1:0]),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// operand select: out of range or never written reads zero, forwarding first
	assign a_val  = !a_ok_s1 ? '0 : (a_byp_s1 ? byp_data_s1 : ram_a);
	assign b_val  = !b_ok_s1 ? '0 : (b_byp_s1 ? byp_data_s1 : ram_b);
	assign or_val = a_val | b_val;

	always_comb begin
		res     = '0;
		wr_data = '0;
		writes  = 1'b0;
		if (!enabled_q) begin
			res.ud_fault = 1'b1;
		end else begin
			case (act)
				ACT_AND: begin
					writes  = 1'b1;
					wr_data = a_val & b_val;
				end
				ACT_ANDN: begin
					writes  = 1'b1;
					wr_data = ~a_val & b_val;
				end
				ACT_OR: begin
					writes  = 1'b1;
					wr_data = or_val;
				end
				ACT_XOR: begin
					writes  = 1'b1;
					wr_data = a_val ^ b_val;
				end
				ACT_XNOR: begin
					writes  = 1'b1;
					wr_data = ~(a_val ^ b_val);
				end
				ACT_NOT: begin
					writes  = 1'b1;
					wr_data = ~a_val;
				end
				ACT_MOVE: begin
					writes  = 1'b1;
					wr_data = a_val;
				end
				ACT_LOAD: begin
					writes  = 1'b1;
					wr_data = item_s1.load_word;
				end
				ACT_STORE: begin
					res.store_valid = 1'b1;
					res.store_word  = a_val;
				end
				ACT_UNPACK: begin
					writes  = 1'b1;
					wr_data = {a_val[BYTE_BITS-1:0], b_val[BYTE_BITS-1:0]};
				end
				ACT_ORTEST: begin
					res.flags_valid = 1'b1;
					res.zero_flag   = (or_val == '0);
					res.carry_flag  = (or_val == MASK_ALL);
				end
				ACT_SHL: begin
					writes  = 1'b1;
					wr_data = (item_s1.shift_count <= MAX_SHIFT) ?
						(a_val << item_s1.shift_count[3:0]) : '0;
				end
				ACT_SHR: begin
					writes  = 1'b1;
					wr_data = (item_s1.shift_count <= MAX_SHIFT) ?
						(a_val >> item_s1.shift_count[3:0]) : '0;
				end
				default: begin
					writes = 1'b0;
				end
			endcase
		end
	end

	assign wr_en = advance && writes && idx_in_range(item_s1.dest_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			valid_s1  <= 1'b0;
			m_tvalid  <= 1'b0;
			vld_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				enabled_q <= cfg_data;
			end
			if (s_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (wr_en) begin
				vld_q[item_s1.dest_index[RAM_AW-1:0]] <= 1'b1;
			end
		end
	end

	// payload, operand validity and forwarding from the item retiring now
	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1     <= in_item;
			byp_data_s1 <= wr_data;
			a_byp_s1    <= wr_en && (item_s1.dest_index == in_item.first_source);
			b_byp_s1    <= wr_en && (item_s1.dest_index == in_item.second_source);
			a_ok_s1     <= idx_in_range(in_item.first_source) &&
				(vld_q[in_item.first_source[RAM_AW-1:0]] ||
				(wr_en && (item_s1.dest_index == in_item.first_source)));
			b_ok_s1     <= idx_in_range(in_item.second_source) &&
				(vld_q[in_item.second_source[RAM_AW-1:0]] ||
				(wr_en && (item_s1.dest_index == in_item.second_source)));
		end
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tdata = {(OUT_W - ITEM_OUT_W)'(0), out_q};

`ifndef SYNTH
	a_fault_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.ud_fault |-> (out_q.store_valid == 1'b0) &&
		(out_q.flags_valid == 1'b0) && (out_q.store_word == '0))
		else $error("fault result carries other fields");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_q.store_valid && out_q.flags_valid))
		else $error("store and flags in one result");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_q.zero_flag && out_q.carry_flag))
		else $error("zero and carry flags both set");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input blocked without a stalled result");

	a_no_write_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> enabled_q && advance)
		else $error("mask written while disabled or not retiring");
`endif

endmodule

// ===== sim/tb_opmask_register_unit.sv =====
module tb_opmask_register_unit;
	import omru_pkg::*;

	localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd13;
	localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;
	localparam int OUT_USED_W   = $bits(out_item_t);
	localparam int DRAIN_CYCLES = 4;
	localparam int STALL_LIMIT  = 2000;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_t;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t result;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_data = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	// typed expectation traveling with the item on the input bus
	logic      drv_typed = 1'b0;
	out_item_t drv_result = '0;

	logic [MASK_W-1:0] mask_model [0:(1<<IDX_W)-1];
	logic              opmask_on;
	out_item_t         pending_results[$];
	stim_row_t         dir_rows[$];
	int                fail_count = 0;
	int                report_count = 0;
	int                idle_cycles = 0;
	int                burst_left = 0;
	rx_mode_t          rx_mode = RX_STREAM;
	int                rx_left = 0;

	opmask_register_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MASK_W-1:0] mask_read(input logic [IDX_W-1:0] idx);
		return ({1'b0, idx} < MASK_REGS) ? mask_model[idx] : '0;
	endfunction

	function automatic void mask_write(input logic [IDX_W-1:0] idx,
			input logic [MASK_W-1:0] val);
		if ({1'b0, idx} < MASK_REGS)
			mask_model[idx] = val;
	endfunction

	function automatic out_item_t exec_mask_action(input in_item_t it);
		out_item_t         r;
		logic [MASK_W-1:0] a;
		logic [MASK_W-1:0] b;
		logic [MASK_W-1:0] t;
		r = '0;
		a = mask_read(it.first_source);
		b = mask_read(it.second_source);
		if (!opmask_on) begin
			r.ud_fault = 1'b1;
			return r;
		end
		case (it.action)
			ACT_AND:    mask_write(it.dest_index, a & b);
			ACT_ANDN:   mask_write(it.dest_index, ~a & b);
			ACT_OR:     mask_write(it.dest_index, a | b);
			ACT_XOR:    mask_write(it.dest_index, a ^ b);
			ACT_XNOR:   mask_write(it.dest_index, ~(a ^ b));
			ACT_NOT:    mask_write(it.dest_index, ~a);
			ACT_MOVE:   mask_write(it.dest_index, a);
			ACT_LOAD:   mask_write(it.dest_index, it.load_word);
			ACT_STORE: begin
				r.store_valid = 1'b1;
				r.store_word  = a;
			end
			ACT_UNPACK: mask_write(it.dest_index, {a[BYTE_BITS-1:0], b[BYTE_BITS-1:0]});
			ACT_ORTEST: begin
				t = a | b;
				r.flags_valid = 1'b1;
				r.zero_flag   = (t == '0);
				r.carry_flag  = (t == MASK_ALL);
			end
			ACT_SHL: begin
				t = (it.shift_count <= MAX_SHIFT) ? (a << it.shift_count) : '0;
				mask_write(it.dest_index, t);
			end
			ACT_SHR: begin
				t = (it.shift_count <= MAX_SHIFT) ? (a >> it.shift_count) : '0;
				mask_write(it.dest_index, t);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic out_item_t mk_result(input logic ud, input logic sv,
			input logic [MASK_W-1:0] word, input logic fv, input logic zf, input logic cf);
		out_item_t r;
		r.ud_fault    = ud;
		r.store_valid = sv;
		r.store_word  = word;
		r.flags_valid = fv;
		r.zero_flag   = zf;
		r.carry_flag  = cf;
		return r;
	endfunction

	function automatic void add_row(input logic [ACT_W-1:0] act, input int dst,
			input int src_a, input int src_b, input int cnt, input int ld,
			input logic typed, input out_item_t res);
		stim_row_t row;
		row.item.action        = act;
		row.item.dest_index    = IDX_W'(dst);
		row.item.first_source  = IDX_W'(src_a);
		row.item.second_source = IDX_W'(src_b);
		row.item.shift_count   = CNT_W'(cnt);
		row.item.load_word     = MASK_W'(ld);
		row.typed              = typed;
		row.result             = res;
		dir_rows.push_back(row);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			it.action = ACT_LOAD;
		else if (pick < 20)
			it.action = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		else
			it.action = ACT_W'($urandom_range(ACT_AND, ACT_SHR));
		it.dest_index    = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		it.first_source  = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		it.second_source = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
		case ($urandom_range(0, 3))
			0, 1: it.shift_count = CNT_W'($urandom_range(0, MAX_SHIFT));
			2:    it.shift_count = CNT_W'($urandom_range(MAX_SHIFT + 1, (1 << CNT_W) - 1));
			default: it.shift_count = CNT_W'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: it.load_word = '0;
			1: it.load_word = MASK_ALL;
			default: it.load_word = MASK_W'($urandom);
		endcase
		return it;
	endfunction

	task automatic send_item(input in_item_t it, input logic typed, input out_item_t res);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		s_tvalid   <= 1'b1;
		s_tdata    <= IN_W'(it);
		drv_typed  <= typed;
		drv_result <= res;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_opmask_enable(input logic en);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(8, 64);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_STREAM: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= (rx_left % 4 == 0);
			default:   m_tready <= (rx_left > 20);
		endcase
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				want = exec_mask_action(in_item_t'(s_tdata[$bits(in_item_t)-1:0]));
				pending_results.push_back(drv_typed ? drv_result : want);
			end
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata[OUT_USED_W-1:0]);
				if (pending_results.size() == 0) begin
					fail_count++;
					if (report_count < MAX_REPORTS)
						$display("unexpected result item %h", m_tdata);
					report_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.ud_fault !== want.ud_fault || got.store_valid !== want.store_valid
							|| got.store_word !== want.store_word
							|| got.flags_valid !== want.flags_valid
							|| got.zero_flag !== want.zero_flag
							|| got.carry_flag !== want.carry_flag) begin
						fail_count++;
						if (report_count < MAX_REPORTS) begin
							$write("mismatch: expected ud=%b sv=%b word=%h fv=%b zf=%b cf=%b",
								want.ud_fault, want.store_valid, want.store_word,
								want.flags_valid, want.zero_flag, want.carry_flag);
							$display(", got ud=%b sv=%b word=%h fv=%b zf=%b cf=%b",
								got.ud_fault, got.store_valid, got.store_word,
								got.flags_valid, got.zero_flag, got.carry_flag);
						end
						report_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				opmask_on = cfg_data;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int first_enabled;
		for (int k = 0; k < (1 << IDX_W); k++)
			mask_model[k] = '0;
		opmask_on = 1'b0;

		// disabled after reset: everything faults
		add_row(ACT_AND,       1, 2, 3, 0, 16'h1234, 1'b1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(ACT_LOAD,      0, 0, 0, 0, 16'hffff, 1'b1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(ACT_STORE,     0, 0, 0, 0, 0,        1'b1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(ACT_ORTEST,    0, 0, 0, 0, 0,        1'b1, mk_result(1, 0, 0, 0, 0, 0));
		add_row(ACT_UNUSED_HI, 7, 7, 7, 255, 16'hffff, 1'b1, mk_result(1, 0, 0, 0, 0, 0));
		first_enabled = dir_rows.size();
		add_row(ACT_STORE,     0, 0, 0, 0, 0,        1'b1, mk_result(0, 1, 0, 0, 0, 0));
		add_row(ACT_ORTEST,    0, 0, 0, 0, 0,        1'b1, mk_result(0, 0, 0, 1, 1, 0));
		add_row(ACT_LOAD,      1, 0, 0, 0, 16'hffff, 1'b1, mk_result(0, 0, 0, 0, 0, 0));
		add_row(ACT_LOAD,      2, 0, 0, 0, 16'h0000, 1'b1, mk_result(0, 0, 0, 0, 0, 0));
		add_row(ACT_STORE,     0, 1, 0, 0, 0,        1'b1, mk_result(0, 1, 16'hffff, 0, 0, 0));
		add_row(ACT_ORTEST,    0, 1, 2, 0, 0,        1'b1, mk_result(0, 0, 0, 1, 0, 1));
		add_row(ACT_LOAD,      3, 0, 0, 0, 16'ha5c3, 1'b0, '0);
		add_row(ACT_LOAD,      4, 0, 0, 0, 16'h0ff0, 1'b0, '0);
		add_row(ACT_AND,       5, 3, 4, 0, 0,        1'b0, '0);
		add_row(ACT_ANDN,      6, 3, 4, 0, 0,        1'b0, '0);
		add_row(ACT_OR,        7, 5, 6, 0, 0,        1'b0, '0);
		add_row(ACT_XOR,       5, 3, 4, 0, 0,        1'b0, '0);
		add_row(ACT_XNOR,      6, 5, 4, 0, 0,        1'b0, '0);
		add_row(ACT_NOT,       7, 3, 0, 0, 0,        1'b0, '0);
		add_row(ACT_MOVE,      0, 7, 0, 0, 0,        1'b0, '0);
		add_row(ACT_UNPACK,    5, 3, 4, 0, 0,        1'b0, '0);
		add_row(ACT_SHL,       6, 1, 0, 15, 0,       1'b0, '0);
		add_row(ACT_SHR,       7, 1, 0, 15, 0,       1'b0, '0);
		add_row(ACT_SHL,       5, 1, 0, 16, 0,       1'b0, '0);
		add_row(ACT_SHR,       4, 3, 0, 255, 0,      1'b0, '0);
		add_row(ACT_UNUSED_LO, 3, 1, 1, 0, 16'hffff, 1'b1, mk_result(0, 0, 0, 0, 0, 0));
		add_row(ACT_ORTEST,    0, 5, 6, 0, 0,        1'b0, '0);
		add_row(ACT_STORE,     0, 6, 0, 0, 0,        1'b0, '0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (i == first_enabled)
				set_opmask_enable(1'b1);
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
		end

		repeat (600) send_item(random_item(), 1'b0, '0);
		set_opmask_enable(1'b0);
		repeat (100) send_item(random_item(), 1'b0, '0);
		set_opmask_enable(1'b1);
		repeat (650) send_item(random_item(), 1'b0, '0);

		wait_drained();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/omru_pkg.sv
rtl/omru_ram.sv
rtl/opmask_register_unit.sv
sim/tb_opmask_register_unit.sv
